// ===== hdl/uwm_pkg.sv =====
// ----------------------------------------------------------------------------
// uwm_pkg: shared types and constants of the utilization window monitor
// Field widths, operation codes, controller states, divider status and the
// percent slew step.
// ----------------------------------------------------------------------------
package uwm_pkg;

  localparam int TS_W       = 32;
  localparam int CATEGORY_W = 3;
  localparam int RATE_W     = 10;
  localparam int PCT_W      = 7;
  localparam int TICK_W     = 20;
  localparam int ENTRY_W    = 16;

  localparam logic OP_RECORD    = 1'b0;
  localparam logic OP_FRAME_END = 1'b1;

  localparam logic [ENTRY_W-1:0] ELAPSED_MAX = '1;
  localparam int                 PCT_SCALE   = 100;
  localparam logic [PCT_W-1:0]   PCT_FULL    = PCT_W'(PCT_SCALE);

  // x / 5 == (x * 205) >> 10 for every x below 1024
  localparam int RECIP5_W     = 8;
  localparam int RECIP5       = 205;
  localparam int RECIP5_SHIFT = 10;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_BUDGET,
    ST_AVG,
    ST_PCT,
    ST_PCT_WAIT,
    ST_PUSH,
    ST_RATE
  } uwm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } uwm_div_stat_t;

  // Move a smoothed percent toward its target by diff/5+1, clamp to full scale.
  function automatic logic [PCT_W-1:0] slew(input logic [PCT_W-1:0] p,
                                            input logic [PCT_W-1:0] tgt);
    logic [PCT_W-1:0]          diff;
    logic [PCT_W+RECIP5_W-1:0] prod;
    logic [PCT_W-1:0]          step;
    logic [PCT_W:0]            res;
    diff = (p > tgt) ? (p - tgt) : (tgt - p);
    prod = (PCT_W + RECIP5_W)'(diff) * (PCT_W + RECIP5_W)'(RECIP5);
    step = PCT_W'(prod >> RECIP5_SHIFT) + PCT_W'(1);
    if (p > tgt) begin
      res = {1'b0, p} - {1'b0, step};
    end else if (p < tgt) begin
      res = {1'b0, p} + {1'b0, step};
    end else begin
      res = {1'b0, p};
    end
    if (res > {1'b0, PCT_FULL}) begin
      res = {1'b0, PCT_FULL};
    end
    return res[PCT_W-1:0];
  endfunction

endpackage

// ===== hdl/uwm_if.sv =====
// ----------------------------------------------------------------------------
// uwm_if: beat channels of the utilization window monitor
// Input channel (record / frame end) and result channel, valid/ready.
// ----------------------------------------------------------------------------
interface uwm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [uwm_pkg::TS_W-1:0]       timestamp;
  logic [uwm_pkg::CATEGORY_W-1:0] category;
  logic [uwm_pkg::RATE_W-1:0]     frame_rate;

  modport source (output valid, operation, timestamp, category, frame_rate,
                  input ready);
  modport sink (input valid, operation, timestamp, category, frame_rate,
                output ready);
endinterface

interface uwm_out_if;
  logic                          valid;
  logic                          ready;
  logic [uwm_pkg::CATEGORY_W-1:0] category_out;
  logic [uwm_pkg::PCT_W-1:0]      percent;
  logic [uwm_pkg::RATE_W-1:0]     average_rate;
  logic [uwm_pkg::TICK_W-1:0]     tick_budget;
  logic                          last;

  modport source (output valid, category_out, percent, average_rate, tick_budget, last,
                  input ready);
  modport sink (input valid, category_out, percent, average_rate, tick_budget, last,
                output ready);
endinterface

// ===== hdl/uwm_ram.sv =====
// ----------------------------------------------------------------------------
// uwm_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module uwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/uwm_div.sv =====
// ----------------------------------------------------------------------------
// uwm_div: restoring divider, one quotient bit per cycle
// The caller pre-shifts the divisor to the weight of the top quotient bit
// and gives the number of quotient bits to produce.
// ----------------------------------------------------------------------------
module uwm_div #(
  parameter int W      = 33,
  parameter int STEP_W = 6
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [W-1:0]           dividend,
  input  logic [W-1:0]           divisor,
  input  logic [STEP_W-1:0]      steps,
  output uwm_pkg::uwm_div_stat_t stat,
  output logic [W-1:0]           quotient
);

  logic [W-1:0]      rem_r;
  logic [W-1:0]      dsr_r;
  logic [W-1:0]      q_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic              ge;

  assign ge = (rem_r >= dsr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == STEP_W'(1));
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend;
      dsr_r <= divisor;
      q_r   <= '0;
      cnt_r <= steps;
    end else if (busy_r) begin
      // take one quotient bit, move the divisor down one place
      if (ge) begin
        rem_r <= rem_r - dsr_r;
      end
      q_r   <= {q_r[W-2:0], ge};
      dsr_r <= dsr_r >> 1;
      cnt_r <= cnt_r - STEP_W'(1);
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

// ===== hdl/utilization_window_monitor_unit.sv =====
// ----------------------------------------------------------------------------
// utilization_window_monitor_unit: per-category busy share over a slot ring
// Records elapsed time per category into the current window slot and, on a
// frame end, reports a smoothed percent for every category plus window stats.
// ----------------------------------------------------------------------------
// A record beat stores min(timestamp - previous timestamp, 65535) for its
// category in the current slot; the next beat can follow at once. A
// frame-end beat advances the slot, then sweeps the elapsed RAM one entry
// per cycle (the frame rate RAM is summed in the same pass), drains the read
// pipeline, computes the tick budget and the average frame rate (both divide
// by the slot count with a reciprocal multiply), then runs the
// one-bit-per-cycle divider once per category for the target percent (a
// start state, a wait state until the divider is done, then a push state
// that loads the output register). Each category result beat is held in an
// output register; the window's new frame rate is written last. A frame end
// holds the input off until that write is done, plus any stall on the
// result channel. After reset the block zeroes both RAMs in a clearing pass
// over every entry and accepts no beat until it is done.
// Percent slew: a percent moves toward its target by |diff|/5+1, clamped to
// 0..100. tick_budget is 1 + total/NUM_SLOTS; an empty window counts as a
// total of one.
// ----------------------------------------------------------------------------
module utilization_window_monitor_unit #(
  parameter int NUM_CATEGORIES = 8,
  parameter int NUM_SLOTS      = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  uwm_in_if.sink     in_bus,
  uwm_out_if.source  out_bus
);

  localparam int CAT_W    = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
  localparam int SLOT_W   = $clog2(NUM_SLOTS);
  localparam int DEPTH    = NUM_CATEGORIES * NUM_SLOTS;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int SUM_W    = uwm_pkg::ENTRY_W + $clog2(NUM_SLOTS);
  localparam int TOT_W    = SUM_W + $clog2(NUM_CATEGORIES);
  localparam int DIV_W    = TOT_W + uwm_pkg::PCT_W;
  localparam int RSUM_W   = uwm_pkg::RATE_W + SLOT_W;
  localparam int STEP_W   = $clog2(DIV_W + 1);

  // x / NUM_SLOTS == (x * ceil(2^SH / NUM_SLOTS)) >> SH for every x of the
  // given width when SH = width + ceil(log2(NUM_SLOTS))
  localparam int     BUD_SH    = TOT_W + SLOT_W;
  localparam int     BUD_PW    = 2 * TOT_W + 1;
  localparam longint BUD_RECIP = ((longint'(1) << BUD_SH) + longint'(NUM_SLOTS)
                                  - longint'(1)) / longint'(NUM_SLOTS);
  localparam int     AVG_SH    = RSUM_W + SLOT_W;
  localparam int     AVG_PW    = 2 * RSUM_W + 1;
  localparam longint AVG_RECIP = ((longint'(1) << AVG_SH) + longint'(NUM_SLOTS)
                                  - longint'(1)) / longint'(NUM_SLOTS);

  localparam logic [CAT_W-1:0]  LAST_CAT  = CAT_W'(NUM_CATEGORIES - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // ---------------------------------------------------------------- state
  uwm_pkg::uwm_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] addr_r;   // sweep / clear address into the elapsed RAM
  logic [SLOT_W-1:0] sj_r;     // slot of addr_r
  logic [CAT_W-1:0]  sc_r;     // category of addr_r
  logic [CAT_W-1:0]  cat_r;    // category being reported

  // read-side pipeline, registered in step with the RAM read of the sweep address
  logic              rd_v_r;
  logic              rd_first_r;
  logic              rd_last_r;
  logic              rd_c0_r;
  logic [CAT_W-1:0]  rd_c_r;

  logic [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]  acc_nxt;
  logic [SUM_W-1:0]  sums_r [NUM_CATEGORIES];
  logic [TOT_W-1:0]  total_r;
  logic [RSUM_W-1:0] rsum_r;

  logic [SLOT_W-1:0]             slot_r;
  logic [uwm_pkg::TS_W-1:0]       prev_r;
  logic [uwm_pkg::PCT_W-1:0]      smooth_r [NUM_CATEGORIES];
  logic [uwm_pkg::RATE_W-1:0]     rate_r;
  logic [uwm_pkg::TICK_W-1:0]     budget_r;
  logic [uwm_pkg::RATE_W-1:0]     avg_r;
  logic [uwm_pkg::PCT_W-1:0]      pct_r;

  logic                          out_valid_r;
  logic [uwm_pkg::CATEGORY_W-1:0] out_cat_r;
  logic [uwm_pkg::PCT_W-1:0]      out_pct_r;
  logic [uwm_pkg::RATE_W-1:0]     out_avg_r;
  logic [uwm_pkg::TICK_W-1:0]     out_tick_r;
  logic                          out_last_r;

  // ---------------------------------------------------------------- memories
  logic                         el_we;
  logic [ADDR_W-1:0]            el_waddr;
  logic [uwm_pkg::ENTRY_W-1:0]  el_wdata;
  logic [ADDR_W-1:0]            el_raddr;
  logic [uwm_pkg::ENTRY_W-1:0]  el_rdata;

  logic                         rt_we;
  logic [SLOT_W-1:0]            rt_waddr;
  logic [uwm_pkg::RATE_W-1:0]   rt_wdata;
  logic [SLOT_W-1:0]            rt_raddr;
  logic [uwm_pkg::RATE_W-1:0]   rt_rdata;

  uwm_ram #(.WIDTH(uwm_pkg::ENTRY_W), .DEPTH(DEPTH)) u_elapsed_ram (
    .clk   (clk),
    .we    (el_we),
    .waddr (el_waddr),
    .wdata (el_wdata),
    .raddr (el_raddr),
    .rdata (el_rdata)
  );

  uwm_ram #(.WIDTH(uwm_pkg::RATE_W), .DEPTH(NUM_SLOTS)) u_rate_ram (
    .clk   (clk),
    .we    (rt_we),
    .waddr (rt_waddr),
    .wdata (rt_wdata),
    .raddr (rt_raddr),
    .rdata (rt_rdata)
  );

  // ---------------------------------------------------------------- divider
  logic                   div_start;
  logic [DIV_W-1:0]       div_dividend;
  logic [DIV_W-1:0]       div_divisor;
  logic [STEP_W-1:0]      div_steps;
  uwm_pkg::uwm_div_stat_t div_stat;
  logic [DIV_W-1:0]       div_q;

  uwm_div #(.W(DIV_W), .STEP_W(STEP_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .steps    (div_steps),
    .stat     (div_stat),
    .quotient (div_q)
  );

  // ---------------------------------------------------------------- datapath helpers
  logic                         in_acc;
  logic                         cat_ok;
  logic [uwm_pkg::TS_W-1:0]     delta;
  logic [uwm_pkg::ENTRY_W-1:0]  elapsed;
  logic [ADDR_W-1:0]            rec_addr;
  logic [TOT_W-1:0]             total_eff;
  logic [uwm_pkg::PCT_W-1:0]    slewed;
  logic                         out_load;
  logic                         last_addr;
  logic [BUD_PW-1:0]            bud_prod;
  logic [AVG_PW-1:0]            avg_prod;

  assign in_acc    = in_bus.valid && in_bus.ready;
  assign cat_ok    = (int'(in_bus.category) < NUM_CATEGORIES);
  assign delta     = in_bus.timestamp - prev_r;
  // saturate the wrapped difference to the entry width
  assign elapsed   = (|delta[uwm_pkg::TS_W-1:uwm_pkg::ENTRY_W]) ?
                     uwm_pkg::ELAPSED_MAX : delta[uwm_pkg::ENTRY_W-1:0];
  assign rec_addr  = ADDR_W'(int'(in_bus.category) * NUM_SLOTS + int'(slot_r));
  // an empty window divides by one
  assign total_eff = (total_r == '0) ? TOT_W'(1) : total_r;
  assign slewed    = uwm_pkg::slew(smooth_r[cat_r], div_q[uwm_pkg::PCT_W-1:0]);
  assign last_addr = (addr_r == LAST_ADDR);
  assign acc_nxt   = (rd_first_r ? '0 : acc_r) + SUM_W'(el_rdata);
  // divide total and rate sum by the slot count
  assign bud_prod  = BUD_PW'(total_eff) * BUD_PW'(BUD_RECIP);
  assign avg_prod  = AVG_PW'(rsum_r) * AVG_PW'(AVG_RECIP);

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      uwm_pkg::ST_CLEAR: begin
        if (last_addr) state_nxt = uwm_pkg::ST_IDLE;
      end
      uwm_pkg::ST_IDLE: begin
        if (in_acc && in_bus.operation == uwm_pkg::OP_FRAME_END) begin
          state_nxt = uwm_pkg::ST_SWEEP;
        end
      end
      uwm_pkg::ST_SWEEP: begin
        if (last_addr) state_nxt = uwm_pkg::ST_DRAIN;
      end
      uwm_pkg::ST_DRAIN:       state_nxt = uwm_pkg::ST_BUDGET;
      uwm_pkg::ST_BUDGET:      state_nxt = uwm_pkg::ST_AVG;
      uwm_pkg::ST_AVG:         state_nxt = uwm_pkg::ST_PCT;
      uwm_pkg::ST_PCT:         state_nxt = uwm_pkg::ST_PCT_WAIT;
      uwm_pkg::ST_PCT_WAIT: begin
        if (div_stat.done) state_nxt = uwm_pkg::ST_PUSH;
      end
      uwm_pkg::ST_PUSH: begin
        if (out_load) begin
          state_nxt = (cat_r == LAST_CAT) ? uwm_pkg::ST_RATE : uwm_pkg::ST_PCT;
        end
      end
      uwm_pkg::ST_RATE:        state_nxt = uwm_pkg::ST_IDLE;
      default:                 state_nxt = uwm_pkg::ST_CLEAR;
    endcase
  end

  // ---------------------------------------------------------------- control outputs
  always_comb begin
    in_bus.ready = 1'b0;
    el_we        = 1'b0;
    el_waddr     = addr_r;
    el_wdata     = '0;
    el_raddr     = addr_r;
    rt_we        = 1'b0;
    rt_waddr     = sj_r;
    rt_wdata     = '0;
    rt_raddr     = sj_r;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    div_steps    = '0;
    out_load     = 1'b0;
    case (state_r)
      uwm_pkg::ST_CLEAR: begin
        // zero one elapsed entry per cycle; rate slots ride on the first category
        el_we = 1'b1;
        rt_we = (sc_r == '0);
      end
      uwm_pkg::ST_IDLE: begin
        in_bus.ready = 1'b1;
        if (in_acc && in_bus.operation == uwm_pkg::OP_RECORD && cat_ok) begin
          el_we    = 1'b1;
          el_waddr = rec_addr;
          el_wdata = elapsed;
        end
      end
      uwm_pkg::ST_PCT: begin
        div_start    = 1'b1;
        div_dividend = DIV_W'(sums_r[cat_r]) * DIV_W'(uwm_pkg::PCT_SCALE);
        div_divisor  = DIV_W'(total_eff) << (uwm_pkg::PCT_W - 1);
        div_steps    = STEP_W'(uwm_pkg::PCT_W);
      end
      uwm_pkg::ST_PUSH: begin
        out_load = !out_valid_r || out_bus.ready;
      end
      uwm_pkg::ST_RATE: begin
        rt_we    = 1'b1;
        rt_waddr = slot_r;
        rt_wdata = rate_r;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------- control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= uwm_pkg::ST_CLEAR;
      addr_r      <= '0;
      sj_r        <= '0;
      sc_r        <= '0;
      cat_r       <= '0;
      rd_v_r      <= 1'b0;
      slot_r      <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        smooth_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      rd_v_r  <= (state_r == uwm_pkg::ST_SWEEP);

      // advance the sweep counters while clearing or summing
      if (state_r == uwm_pkg::ST_CLEAR || state_r == uwm_pkg::ST_SWEEP) begin
        addr_r <= last_addr ? '0 : addr_r + ADDR_W'(1);
        if (sj_r == LAST_SLOT) begin
          sj_r <= '0;
          sc_r <= (sc_r == LAST_CAT) ? '0 : sc_r + CAT_W'(1);
        end else begin
          sj_r <= sj_r + SLOT_W'(1);
        end
      end

      if (state_r == uwm_pkg::ST_IDLE && in_acc) begin
        if (in_bus.operation == uwm_pkg::OP_RECORD) begin
          prev_r <= in_bus.timestamp;
        end else begin
          slot_r <= (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
        end
      end

      if (state_r == uwm_pkg::ST_AVG) begin
        cat_r <= '0;
      end
      if (state_r == uwm_pkg::ST_PCT_WAIT && div_stat.done) begin
        smooth_r[cat_r] <= slewed;
      end
      if (out_load) begin
        cat_r <= (cat_r == LAST_CAT) ? '0 : cat_r + CAT_W'(1);
      end

      // hold the result beat until taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload registers
  always_ff @(posedge clk) begin
    rd_first_r <= (sj_r == '0);
    rd_last_r  <= (sj_r == LAST_SLOT);
    rd_c0_r    <= (sc_r == '0);
    rd_c_r     <= sc_r;

    if (state_r == uwm_pkg::ST_IDLE && in_acc) begin
      rate_r  <= in_bus.frame_rate;
      total_r <= '0;
      rsum_r  <= '0;
    end

    // accumulate the registered entry read from the sweep address
    if (rd_v_r) begin
      acc_r   <= acc_nxt;
      total_r <= total_r + TOT_W'(el_rdata);
      if (rd_last_r) begin
        sums_r[rd_c_r] <= acc_nxt;
      end
      if (rd_c0_r) begin
        rsum_r <= rsum_r + RSUM_W'(rt_rdata);
      end
    end

    if (state_r == uwm_pkg::ST_BUDGET) begin
      budget_r <= uwm_pkg::TICK_W'(bud_prod[BUD_PW-1:BUD_SH]) + uwm_pkg::TICK_W'(1);
    end
    if (state_r == uwm_pkg::ST_AVG) begin
      avg_r <= uwm_pkg::RATE_W'(avg_prod[AVG_PW-1:AVG_SH]);
    end
    if (state_r == uwm_pkg::ST_PCT_WAIT && div_stat.done) begin
      pct_r <= slewed;
    end

    if (out_load) begin
      out_cat_r  <= uwm_pkg::CATEGORY_W'(cat_r);
      out_pct_r  <= pct_r;
      out_avg_r  <= avg_r;
      out_tick_r <= budget_r;
      out_last_r <= (cat_r == LAST_CAT);
    end
  end

  assign out_bus.valid        = out_valid_r;
  assign out_bus.category_out = out_cat_r;
  assign out_bus.percent      = out_pct_r;
  assign out_bus.average_rate = out_avg_r;
  assign out_bus.tick_budget  = out_tick_r;
  assign out_bus.last         = out_last_r;

endmodule
